### sv/vfpe_pkg.sv
`timescale 1ns / 1ps
// vfpe_pkg: types, codes and float32 helpers for the vector field program evaluator.
// No dependencies; imported by vector_field_program_eval.
package vfpe_pkg;

   localparam int VFPE_SLOTS = 64;
   localparam int LANES      = 16;
   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

   // instruction opcodes; the spare code is ignored
   typedef enum logic [2:0] {
      OP_LINEAR = 3'd0,
      OP_SUMSQ  = 3'd1,
      OP_LE     = 3'd2,
      OP_GE     = 3'd3,
      OP_AND    = 3'd4,
      OP_OR     = 3'd5,
      OP_RET    = 3'd6
   } op_type;

   // item kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EXEC = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL1,
      ST_MUL2,
      ST_ADD1,
      ST_ADD2,
      ST_WRITE,
      ST_RREAD,
      ST_RSEND
   } state_type;

   typedef struct packed {
      logic        req_type;
      logic [3:0]  lane;
      logic [31:0] point_x;
      logic [31:0] point_y;
      logic [2:0]  opcode;
      logic [5:0]  src_a;
      logic [5:0]  src_b;
      logic [31:0] coef_a;
      logic [31:0] coef_b;
      logic [31:0] coef_c;
      logic [31:0] threshold;
   } req_item_type;

   typedef struct packed {
      logic [3:0]  out_lane;
      logic [31:0] out_value;
      logic        out_last;
   } rsp_type;

   // position of the highest set bit counted from the top (p nonzero)
   function automatic logic [5:0] lzc48(logic [47:0] p);
      logic [5:0] n;
      begin
         n = 6'd0;
         for (int i = 0; i < 48; i++) begin
            if (p[i]) n = 6'(47 - i);
         end
         return n;
      end
   endfunction

   // round to nearest even and pack; sig has its leading one at bit 47
   function automatic logic [31:0] fp_round(logic s, logic signed [11:0] e,
                                            logic [47:0] sig);
      logic [47:0] sr;
      logic        lost;
      logic        g;
      logic        st;
      logic        rnd;
      logic [23:0] m;
      logic [7:0]  ef;
      logic [30:0] pk;
      logic [11:0] sh;
      begin
         if (e >= 12'sd255) return {s, 8'hFF, 23'd0};
         if (e >= 12'sd1) begin
            sr   = sig;
            lost = 1'b0;
            ef   = e[7:0];
         end else begin
            // subnormal: denormalize with sticky
            sh = 12'(12'sd1 - e);
            if (sh > 12'd48) sh = 12'd48;
            sr   = sig >> sh;
            lost = |(sig & ~({48{1'b1}} << sh));
            ef   = 8'd0;
         end
         m   = sr[47:24];
         g   = sr[23];
         st  = (|sr[22:0]) | lost;
         rnd = g & (st | m[0]);
         pk  = {ef, m[22:0]} + 31'(rnd);
         return {s, pk};
      end
   endfunction

   function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
      logic        s;
      logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic [7:0]  eae, ebe;
      logic [23:0] ma, mb;
      logic [47:0] p;
      logic [5:0]  lz;
      logic signed [11:0] e;
      begin
         s      = a[31] ^ b[31];
         a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
         b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
         a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
         b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
         a_zero = (a[30:0] == 31'd0);
         b_zero = (b[30:0] == 31'd0);
         if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) return CANON_NAN;
         if (a_inf || b_inf) return {s, 8'hFF, 23'd0};
         if (a_zero || b_zero) return {s, 31'd0};
         ma  = {a[30:23] != 8'd0, a[22:0]};
         mb  = {b[30:23] != 8'd0, b[22:0]};
         eae = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
         ebe = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
         p   = ma * mb;
         lz  = lzc48(p);
         e   = $signed({4'd0, eae}) + $signed({4'd0, ebe}) - 12'sd126
               - $signed({6'd0, lz});
         return fp_round(s, e, p << lz);
      end
   endfunction

   function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
      logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic [31:0] big, sml;
      logic [7:0]  ebig, esml, d;
      logic [47:0] va, vb0, vb, sig;
      logic        lost;
      logic [48:0] sum;
      logic [5:0]  lz;
      logic signed [11:0] e;
      begin
         a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
         b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
         a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
         b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
         a_zero = (a[30:0] == 31'd0);
         b_zero = (b[30:0] == 31'd0);
         if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) return CANON_NAN;
         if (a_inf) return a;
         if (b_inf) return b;
         if (a_zero && b_zero) return {a[31] & b[31], 31'd0};
         if (a_zero) return b;
         if (b_zero) return a;
         if (a[30:0] >= b[30:0]) begin
            big = a;
            sml = b;
         end else begin
            big = b;
            sml = a;
         end
         ebig = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
         esml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
         d    = ebig - esml;
         va   = {big[30:23] != 8'd0, big[22:0], 24'd0};
         vb0  = {sml[30:23] != 8'd0, sml[22:0], 24'd0};
         // align the smaller operand, folding shifted-out bits into a sticky lsb
         if (d >= 8'd48) begin
            vb   = 48'd0;
            lost = 1'b1;
         end else begin
            vb   = vb0 >> d;
            lost = |(vb0 & ~({48{1'b1}} << d));
         end
         vb[0] = vb[0] | lost;
         if (big[31] != sml[31]) sum = {1'b0, va} - {1'b0, vb};
         else                    sum = {1'b0, va} + {1'b0, vb};
         if (sum == 49'd0) return 32'd0;
         if (sum[48]) begin
            sig = {sum[48:2], sum[1] | sum[0]};
            e   = $signed({4'd0, ebig}) + 12'sd1;
         end else begin
            lz  = lzc48(sum[47:0]);
            sig = sum[47:0] << lz;
            e   = $signed({4'd0, ebig}) - $signed({6'd0, lz});
         end
         return fp_round(big[31], e, sig);
      end
   endfunction

   // ordered a <= b; false on NaN, signed zeros equal
   function automatic logic fp_le(logic [31:0] a, logic [31:0] b);
      logic [31:0] ka, kb;
      begin
         if (((a[30:23] == 8'hFF) && (a[22:0] != 23'd0)) ||
             ((b[30:23] == 8'hFF) && (b[22:0] != 23'd0))) return 1'b0;
         if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b1;
         ka = a[31] ? ~a : (a ^ 32'h8000_0000);
         kb = b[31] ? ~b : (b ^ 32'h8000_0000);
         return ka <= kb;
      end
   endfunction

endpackage

### sv/vector_field_program_eval.sv
`timescale 1ns / 1ps
// vector_field_program_eval: 16-lane float32 straight-line program evaluator.
// Depends on vfpe_pkg (types, opcodes, float32 multiply/add/compare functions).
//
//   channel   dir  payload        handshake
//   req_*     in   req_item_type  req_valid / req_stall
//   rsp_*     out  rsp_type       rsp_valid / rsp_stall
//
// Load items are taken in idle and leave the sequencer there. An instruction runs
// lane by lane through one shared float multiplier and one shared float adder: per
// lane, affine steps through read, mul1, mul2, add1, add2 and write, sumsq skips add2,
// and compare/and/or go from read straight to write. Return steps through read and
// send for each lane (the slot memory read port is registered).
// Reset (synchronous) clears state, lane, position and output valid; the point and
// slot memories are not cleared. Output stalls hold the sequencer in a return.
module vector_field_program_eval
   import vfpe_pkg::*;
#(
   parameter int SLOTS = VFPE_SLOTS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW = $clog2(SLOTS + 1);
   localparam int AW = SW + 4;

   state_type   state_ff, state_in;
   logic [3:0]  lane_ff, lane_in;
   logic [PW-1:0] pos_ff, pos_in;
   req_item_type cmd_ff;
   logic [31:0] px_ff [LANES];
   logic [31:0] py_ff [LANES];
   logic [31:0] slot_mem [SLOTS*LANES];
   logic [31:0] rda_ff, rdb_ff;
   logic [31:0] t_ff, u_ff, s_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;

   logic        accept, out_free, out_load, wr_en;
   logic        sa_ok, sb_ok;
   logic [31:0] va, vb;
   logic [31:0] mul_a, mul_b, mul_res;
   logic [31:0] add_a, add_b, add_res;
   logic [31:0] res;
   logic [AW-1:0] addr_a, addr_b, addr_w;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // operand slots at or above SLOTS read as zero
   assign sa_ok  = 32'(cmd_ff.src_a) < SLOTS;
   assign sb_ok  = 32'(cmd_ff.src_b) < SLOTS;
   assign va     = sa_ok ? rda_ff : 32'd0;
   assign vb     = sb_ok ? rdb_ff : 32'd0;
   assign addr_a = {SW'(cmd_ff.src_a), lane_ff};
   assign addr_b = {SW'(cmd_ff.src_b), lane_ff};
   assign addr_w = {pos_ff[SW-1:0], lane_ff};

   // sequencer: next state and strobes
   always_comb begin
      state_in = state_ff;
      lane_in  = lane_ff;
      pos_in   = pos_ff;
      wr_en    = 1'b0;
      out_load = 1'b0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_data.req_type == REQ_EXEC)) begin
               if (req_data.opcode == OP_RET) begin
                  state_in = ST_RREAD;
                  pos_in   = '0;
               end else if ((req_data.opcode inside {[OP_LINEAR:OP_OR]}) &&
                            (pos_ff < PW'(SLOTS))) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            if ((cmd_ff.opcode == OP_LINEAR) || (cmd_ff.opcode == OP_SUMSQ))
               state_in = ST_MUL1;
            else
               state_in = ST_WRITE;
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_ADD1;
         ST_ADD1: state_in = (cmd_ff.opcode == OP_LINEAR) ? ST_ADD2 : ST_WRITE;
         ST_ADD2: state_in = ST_WRITE;
         ST_WRITE: begin
            wr_en   = 1'b1;
            lane_in = lane_ff + 4'd1;
            if (lane_ff == 4'(LANES - 1)) begin
               state_in = ST_IDLE;
               pos_in   = pos_ff + PW'(1);
            end else begin
               state_in = ST_READ;
            end
         end
         ST_RREAD: state_in = ST_RSEND;
         ST_RSEND: begin
            if (out_free) begin
               out_load = 1'b1;
               lane_in  = lane_ff + 4'd1;
               state_in = (lane_ff == 4'(LANES - 1)) ? ST_IDLE : ST_RREAD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // shared multiply and add operand selection
   always_comb begin
      mul_a = va;
      mul_b = va;
      add_a = t_ff;
      add_b = u_ff;
      if (state_ff == ST_MUL2) begin
         mul_a = vb;
         mul_b = vb;
      end
      if (cmd_ff.opcode == OP_LINEAR) begin
         mul_a = (state_ff == ST_MUL2) ? cmd_ff.coef_b : cmd_ff.coef_a;
         mul_b = (state_ff == ST_MUL2) ? py_ff[lane_ff] : px_ff[lane_ff];
      end
      if (state_ff == ST_ADD2) begin
         add_a = s_ff;
         add_b = cmd_ff.coef_c;
      end
   end

   assign mul_res = fp_mul(mul_a, mul_b);
   assign add_res = fp_add(add_a, add_b);

   // lane result
   always_comb begin
      case (cmd_ff.opcode)
         OP_LINEAR, OP_SUMSQ: res = s_ff;
         OP_LE:  res = fp_le(va, cmd_ff.threshold) ? 32'hFFFF_FFFF : 32'd0;
         OP_GE:  res = fp_le(cmd_ff.threshold, va) ? 32'hFFFF_FFFF : 32'd0;
         OP_AND: res = va & vb;
         default: res = va | vb;
      endcase
   end

   // output register
   always_comb begin
      if (out_load)       rsp_valid_in = 1'b1;
      else if (rsp_stall) rsp_valid_in = rsp_valid_ff;
      else                rsp_valid_in = 1'b0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lane_ff      <= 4'd0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lane_ff      <= lane_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) cmd_ff <= req_data;
      if (accept && (req_data.req_type == REQ_LOAD)) begin
         px_ff[req_data.lane] <= req_data.point_x;
         py_ff[req_data.lane] <= req_data.point_y;
      end
      if (state_ff == ST_MUL1) t_ff <= mul_res;
      if (state_ff == ST_MUL2) u_ff <= mul_res;
      if ((state_ff == ST_ADD1) || (state_ff == ST_ADD2)) s_ff <= add_res;
      if (out_load) begin
         rsp_data_ff.out_lane  <= lane_ff;
         rsp_data_ff.out_value <= va;
         rsp_data_ff.out_last  <= (lane_ff == 4'(LANES - 1));
      end
   end

   // slot memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) slot_mem[addr_w] <= res;
      rda_ff <= slot_mem[addr_a];
      rdb_ff <= slot_mem[addr_b];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_rsp_from_return: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RSEND))
      else $error("result shown outside a return");
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (pos_ff < PW'(SLOTS)))
      else $error("slot write past program end");
   a_last_lane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.out_last) |-> (rsp_data_ff.out_lane == 4'(LANES - 1)))
      else $error("last flag on wrong lane");
   a_idle_lane_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (lane_ff == 4'd0))
      else $error("lane counter not rewound");

endmodule

### tb/vector_field_program_eval_checker.sv
`timescale 1ns / 1ps
// vector_field_program_eval_checker: watches both channels of the evaluator, predicts each
// returned lane and compares it with the transfer seen. Depends on vfpe_pkg.
module vector_field_program_eval_checker
   import vfpe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_item_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_type      rsp_data,
   output int           fail_count,
   output int           lanes_pending
);

   logic [31:0] x_lane [LANES];
   logic [31:0] y_lane [LANES];
   logic [31:0] slot_val [VFPE_SLOTS][LANES];
   int          prog_pos;
   rsp_type     lane_q [$];

   function automatic logic is_nan32(logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   // widen float32 bits to a double; exact for every input but a NaN, whose payload is not kept
   function automatic real to_real(logic [31:0] v);
      logic [63:0] d;
      logic [23:0] mm;
      int          ex;
      if (v[30:23] == 8'hFF)
         d = {v[31], 11'h7FF, (v[22:0] != 0) ? {1'b1, 51'd0} : 52'd0};
      else if (v[30:0] == 31'd0)
         d = {v[31], 63'd0};
      else begin
         mm = {v[30:23] != 8'd0, v[22:0]};
         ex = (v[30:23] == 8'd0) ? 1 : int'(v[30:23]);
         while (!mm[23]) begin
            mm = mm << 1;
            ex--;
         end
         d = {v[31], 11'(ex - 127 + 1023), mm[22:0], 29'd0};
      end
      return $bitstoreal(d);
   endfunction

   // round a double to float32, nearest even, subnormals kept, NaN made canonical.
   // A double holds products exactly and sums with enough margin for one clean rounding.
   function automatic logic [31:0] to_f32(real r);
      logic [63:0] d;
      logic [63:0] sig;
      logic [63:0] m;
      logic [31:0] pk;
      logic        g, st, rnd;
      int          fe, sh;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? CANON_NAN : {d[63], 8'hFF, 23'd0};
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      fe = int'(d[62:52]) - 1023 + 127;
      if (fe >= 255) return {d[63], 8'hFF, 23'd0};
      sig = {11'd0, 1'b1, d[51:0]};
      sh  = 29;
      if (fe < 1) begin
         sh = 29 + 1 - fe;
         fe = 0;
      end
      if (sh > 62) sh = 62;
      m   = sig >> sh;
      g   = sig[sh-1];
      st  = |(sig & ((64'd1 << (sh - 1)) - 64'd1));
      rnd = g & (st | m[0]);
      pk  = (32'(fe) << 23) + ((fe >= 1) ? {9'd0, m[22:0]} : m[31:0]) + 32'(rnd);
      return {d[63], pk[30:0]};
   endfunction

   function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
      return to_f32(to_real(a) * to_real(b));
   endfunction

   function automatic logic [31:0] add32(logic [31:0] a, logic [31:0] b);
      return to_f32(to_real(a) + to_real(b));
   endfunction

   // one instruction over all lanes; return queues the sixteen lane values
   task automatic run_item(req_item_type it);
      logic [31:0] lane_res [LANES];
      logic [31:0] va, vb;
      rsp_type     r;
      if (it.req_type == REQ_LOAD) begin
         x_lane[it.lane] = it.point_x;
         y_lane[it.lane] = it.point_y;
      end else if (it.opcode == OP_RET) begin
         for (int ln = 0; ln < LANES; ln++) begin
            r.out_lane  = 4'(ln);
            r.out_value = slot_val[it.src_a][ln];
            r.out_last  = (ln == LANES - 1);
            lane_q.push_back(r);
         end
         prog_pos = 0;
      end else if (it.opcode <= OP_OR && prog_pos < VFPE_SLOTS) begin
         for (int ln = 0; ln < LANES; ln++) begin
            va = slot_val[it.src_a][ln];
            vb = slot_val[it.src_b][ln];
            case (it.opcode)
               OP_LINEAR: lane_res[ln] = add32(add32(mul32(it.coef_a, x_lane[ln]),
                                                     mul32(it.coef_b, y_lane[ln])), it.coef_c);
               OP_SUMSQ:  lane_res[ln] = add32(mul32(va, va), mul32(vb, vb));
               OP_LE:     lane_res[ln] = (!is_nan32(va) && !is_nan32(it.threshold) &&
                                          to_real(va) <= to_real(it.threshold)) ? '1 : '0;
               OP_GE:     lane_res[ln] = (!is_nan32(va) && !is_nan32(it.threshold) &&
                                          to_real(va) >= to_real(it.threshold)) ? '1 : '0;
               OP_AND:    lane_res[ln] = va & vb;
               default:   lane_res[ln] = va | vb;
            endcase
         end
         for (int ln = 0; ln < LANES; ln++) slot_val[prog_pos][ln] = lane_res[ln];
         prog_pos++;
      end
   endtask

   // predict on input transfers, compare on output transfers
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count = 0;
         prog_pos   = 0;
         lane_q.delete();
         for (int ln = 0; ln < LANES; ln++) begin
            x_lane[ln] = '0;
            y_lane[ln] = '0;
            for (int s = 0; s < VFPE_SLOTS; s++) slot_val[s][ln] = '0;
         end
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (lane_q.size() == 0) begin
               $display("%0t: unexpected lane transfer %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = lane_q.pop_front();
               if (rsp_data.out_lane !== want.out_lane) begin
                  $display("%0t: out_lane expected %0d actual %0d", $time,
                           want.out_lane, rsp_data.out_lane);
                  fail_count++;
               end
               if (rsp_data.out_value !== want.out_value) begin
                  $display("%0t: out_value lane %0d expected %h actual %h", $time,
                           want.out_lane, want.out_value, rsp_data.out_value);
                  fail_count++;
               end
               if (rsp_data.out_last !== want.out_last) begin
                  $display("%0t: out_last lane %0d expected %b actual %b", $time,
                           want.out_lane, want.out_last, rsp_data.out_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) run_item(req_data);
      end
      lanes_pending = lane_q.size();
   end

endmodule

### tb/vector_field_program_eval_test.sv
`timescale 1ns / 1ps
// vector_field_program_eval_test: stimulus and verdict for the program evaluator.
// Depends on vfpe_pkg, vector_field_program_eval and vector_field_program_eval_checker.
module vector_field_program_eval_test;
   import vfpe_pkg::*;

   localparam logic [2:0] OP_SPARE   = 3'd7;
   localparam int         CYCLE_CAP  = 600000;
   localparam int         HOLD_START = 3000;
   localparam int         HOLD_LEN   = 400;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_type      rsp_data;
   int           fail_count;
   int           lanes_pending;
   int           cycle_count = 0;
   int           item_count;
   logic         slot_written [VFPE_SLOTS];
   int           shadow_pos;

   vector_field_program_eval dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   vector_field_program_eval_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .lanes_pending(lanes_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // float patterns weighted toward the special encodings
   function automatic logic [31:0] rand_f32();
      case ($urandom_range(0, 11))
         0:  return 32'h0000_0000;
         1:  return 32'h8000_0000;
         2:  return {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};
         3:  return {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
         4:  return {1'($urandom), 8'd0, 23'($urandom)};
         5:  return {1'($urandom), 8'($urandom_range(250, 254)), 23'($urandom)};
         6:  return {1'($urandom), 8'($urandom_range(1, 8)), 23'($urandom)};
         7:  return 32'h3F80_0000;
         default: return {1'($urandom), 8'($urandom_range(100, 154)), 23'($urandom)};
      endcase
   endfunction

   // slot 0 is always the first one written; before that any index does for affine
   function automatic logic [5:0] written_slot();
      int s;
      if (!slot_written[0]) return 6'($urandom_range(0, VFPE_SLOTS - 1));
      do s = $urandom_range(0, VFPE_SLOTS - 1); while (!slot_written[s]);
      return 6'(s);
   endfunction

   // one input transfer with an optional idle gap ahead of it
   task automatic push_item(req_item_type it);
      if (!(item_count >= 100 && item_count < 170) && $urandom_range(0, 99) < 20) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_data  = it;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      item_count++;
   endtask

   task automatic load_lane(logic [3:0] ln, logic [31:0] x, logic [31:0] y);
      req_item_type it;
      logic [319:0] noise;
      noise       = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom};
      it          = noise[$bits(req_item_type)-1:0];
      it.req_type = REQ_LOAD;
      it.lane     = ln;
      it.point_x  = x;
      it.point_y  = y;
      push_item(it);
   endtask

   // instruction with random coefficients; source slots only from written ones
   task automatic exec_op(logic [2:0] op, logic [31:0] thr);
      req_item_type it;
      logic [319:0] noise;
      noise        = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom};
      it           = noise[$bits(req_item_type)-1:0];
      it.req_type  = REQ_EXEC;
      it.opcode    = op;
      it.src_a     = written_slot();
      it.src_b     = written_slot();
      it.coef_a    = rand_f32();
      it.coef_b    = rand_f32();
      it.coef_c    = rand_f32();
      it.threshold = thr;
      if (op == OP_RET)
         shadow_pos = 0;
      else if (op <= OP_OR && shadow_pos < VFPE_SLOTS) begin
         slot_written[shadow_pos] = 1'b1;
         shadow_pos++;
      end
      push_item(it);
   endtask

   // receiver: random stalls, one stall-free stretch and one long hold-off
   initial begin
      int n;
      rsp_stall = 1'b0;
      n = 0;
      forever begin
         @(negedge clock);
         n++;
         if (n >= HOLD_START && n < HOLD_START + HOLD_LEN)
            rsp_stall = 1'b1;
         else if (n >= 8000 && n < 14000)
            rsp_stall = 1'b0;
         else
            rsp_stall = ($urandom_range(0, 99) < 20);
      end
   end

   initial begin
      logic [2:0] op;
      int         k;
      item_count  = 0;
      shadow_pos  = 0;
      for (int s = 0; s < VFPE_SLOTS; s++) slot_written[s] = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: lanes 0 to 5 loaded with extreme points, the rest random, then each opcode
      load_lane(4'd0, 32'h0000_0000, 32'h8000_0000);
      load_lane(4'd1, 32'h7F80_0000, 32'hFF80_0000);
      load_lane(4'd2, 32'h7FC0_0001, 32'h3F80_0000);
      load_lane(4'd3, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
      load_lane(4'd4, 32'h0000_0001, 32'h8000_0001);
      load_lane(4'd5, 32'hFFFF_FFFF, 32'h0080_0000);
      for (int ln = 6; ln < LANES; ln++) load_lane(4'(ln), rand_f32(), rand_f32());
      exec_op(OP_LINEAR, rand_f32());
      exec_op(OP_SUMSQ, rand_f32());
      exec_op(OP_LE, 32'h0000_0000);
      exec_op(OP_GE, 32'h7FC0_0000);
      exec_op(OP_AND, rand_f32());
      exec_op(OP_OR, rand_f32());
      exec_op(OP_SPARE, rand_f32());
      exec_op(OP_RET, rand_f32());
      exec_op(OP_RET, rand_f32());

      // random programs; one of them overruns the slot count
      k = 0;
      while (item_count < 350) begin
         k++;
         if (k == 60) begin
            for (int i = 0; i < VFPE_SLOTS + 6; i++)
               exec_op(($urandom_range(0, 1) == 1) ? OP_AND : OP_LE, rand_f32());
            exec_op(OP_RET, rand_f32());
         end else if ($urandom_range(0, 99) < 8) begin
            load_lane(4'($urandom), rand_f32(), rand_f32());
         end else begin
            case ($urandom_range(0, 14))
               0, 1, 2: op = OP_LINEAR;
               3, 4:    op = OP_SUMSQ;
               5:       op = OP_LE;
               6:       op = OP_GE;
               7:       op = OP_AND;
               8:       op = OP_OR;
               9:       op = OP_SPARE;
               default: op = OP_RET;
            endcase
            exec_op(op, rand_f32());
         end
      end
      req_valid = 1'b0;

      while (lanes_pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
